// File: rtl/hypotrochoid_point_generator_unit_defines.svh
// Assertion macros for the hypotrochoid point generator.
`ifndef HYPOTROCHOID_POINT_GENERATOR_UNIT_DEFINES_SVH
`define HYPOTROCHOID_POINT_GENERATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define HPG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpg: implication check failed");
// next-cycle implication
`define HPG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpg: next-cycle check failed");
`else
`define HPG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HPG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/hpg_pkg.sv
// Shared constants and types of the hypotrochoid point generator.
`timescale 1ns / 1ps
`default_nettype none

package hpg_pkg;

    // default parameter values
    localparam int PHASE_BITS_DEF       = 24;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;

    // pi/2 in Q30, used to build the sine table
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // register indexes
    localparam cfg_idx_t REG_CENTER_X    = 3'd0;
    localparam cfg_idx_t REG_CENTER_Y    = 3'd1;
    localparam cfg_idx_t REG_RING_RADIUS = 3'd2;
    localparam cfg_idx_t REG_PEN_RADIUS  = 3'd3;
    localparam cfg_idx_t REG_OUTER_STEP  = 3'd4;
    localparam cfg_idx_t REG_INNER_STEP  = 3'd5;

    // register widths and reset values
    localparam int CENTER_W = 10;
    localparam int RADIUS_W = 16;
    localparam int STEP_W   = 24;

    localparam logic [CENTER_W-1:0] CENTER_X_RST    = 10'd159;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST    = 10'd99;
    localparam logic [RADIUS_W-1:0] RING_RADIUS_RST = 16'd533;
    localparam logic [RADIUS_W-1:0] PEN_RADIUS_RST  = 16'd1067;
    localparam logic [STEP_W-1:0]   OUTER_STEP_RST  = 24'd167772;
    localparam logic [STEP_W-1:0]   INNER_STEP_RST  = 24'd167772;

    // sine values: Q1.15 magnitude with sign
    localparam int SINE_MAG_W = 16;
    typedef logic signed [SINE_MAG_W:0] sine_t;

    // output coordinates
    localparam int COORD_W   = 13;
    localparam int COORD_MAX = 4095;
    localparam int COORD_MIN = -4096;
    typedef logic signed [COORD_W-1:0] coord_t;

    // radius (Q12.4) times sine (Q1.15) gives Q.19
    localparam int FRAC_BITS = 19;
    localparam int PROD_W    = 2 * (SINE_MAG_W + 1);
    localparam int SUM_W     = PROD_W + 2;

endpackage

`default_nettype wire

// File: rtl/hpg_if.sv
// Channel interfaces: step requests, points and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface hpg_step_if
    import hpg_pkg::*;
    ();
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface hpg_point_if
    import hpg_pkg::*;
    ();
    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink (input valid, input point_x, input point_y, output ready);
endinterface

interface hpg_cfg_if
    import hpg_pkg::*;
    ();
    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/hypotrochoid_point_generator_unit.sv
// Top level of the hypotrochoid point generator.
`timescale 1ns / 1ps
`default_nettype none

// Each step beat advances the outer and inner phase by their steps (restart
// clears both first) and yields one point beat:
//   x = center_x + R*cos(outer) + H*cos(inner)
//   y = center_y - R*sin(outer) + H*sin(inner)
// truncated toward zero and saturated to -4096..4095. One step beat is taken
// every cycle unless a point beat waits. The rate is set by the
// read-modify-write loop on the phase memory, which forwards the value just
// written to a step read in the same cycle. The phase memory is marked empty
// at reset and reads as zero until first written, so no clearing pass is
// needed. The whole pipeline holds while a point beat waits.
// Configuration beats are always accepted; write only while idle.

`include "hypotrochoid_point_generator_unit_defines.svh"

module hypotrochoid_point_generator_unit
    import hpg_pkg::*;
#(
    parameter int PHASE_BITS       = PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    hpg_cfg_if.sink    cfg,
    hpg_step_if.sink   step,
    hpg_point_if.source point
);

    localparam int PAIR_W = 2 * PHASE_BITS;
    localparam int Q_W    = SUM_W - FRAC_BITS;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(COORD_MAX);
    localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(COORD_MIN);

    // configuration registers
    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    logic [RADIUS_W-1:0] ring_radius_reg;
    logic [RADIUS_W-1:0] pen_radius_reg;
    logic [STEP_W-1:0]   outer_step_reg;
    logic [STEP_W-1:0]   inner_step_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= CENTER_X_RST;
            center_y_reg    <= CENTER_Y_RST;
            ring_radius_reg <= RING_RADIUS_RST;
            pen_radius_reg  <= PEN_RADIUS_RST;
            outer_step_reg  <= OUTER_STEP_RST;
            inner_step_reg  <= INNER_STEP_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_CENTER_X:    center_x_reg    <= cfg.data[CENTER_W-1:0];
                REG_CENTER_Y:    center_y_reg    <= cfg.data[CENTER_W-1:0];
                REG_RING_RADIUS: ring_radius_reg <= cfg.data[RADIUS_W-1:0];
                REG_PEN_RADIUS:  pen_radius_reg  <= cfg.data[RADIUS_W-1:0];
                REG_OUTER_STEP:  outer_step_reg  <= cfg.data[STEP_W-1:0];
                REG_INNER_STEP:  inner_step_reg  <= cfg.data[STEP_W-1:0];
                default:         ;
            endcase
        end
    end

    // pipeline enable: everything moves unless a point beat is stuck
    logic adv;
    logic step_acc;
    logic out_valid_reg;

    assign adv        = !out_valid_reg || point.ready;
    assign step.ready = adv;
    assign step_acc   = step.valid && adv;

    // valid chain
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic s5_valid_reg;
    logic s6_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= step.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            out_valid_reg <= s6_valid_reg;
        end
    end

    // phase memory: {outer, inner}, one entry
    logic [PAIR_W-1:0]     phase_mem [0:0];
    logic [PAIR_W-1:0]     rd_data_reg;
    logic                  rd_valid_reg;
    logic                  mem_valid_reg;
    logic                  fwd_hit_reg;
    logic [PAIR_W-1:0]     fwd_val_reg;
    logic                  s1_restart_reg;
    logic                  mem_we;
    logic [PAIR_W-1:0]     base_pair;
    logic [PHASE_BITS-1:0] outer_next;
    logic [PHASE_BITS-1:0] inner_next;

    assign mem_we = s1_valid_reg && adv;

    // read on accept, write back when stage 1 advances
    always_ff @(posedge clk)
    begin
        if (step_acc)
        begin
            rd_data_reg <= phase_mem[0];
        end
        if (mem_we)
        begin
            phase_mem[0] <= {outer_next, inner_next};
            fwd_val_reg  <= {outer_next, inner_next};
        end
        if (adv)
        begin
            s1_restart_reg <= step.restart;
        end
    end

    // entry-valid and forwarding control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                mem_valid_reg <= 1'b1;
            end
            if (step_acc)
            begin
                rd_valid_reg <= mem_valid_reg;
                // a write at the same edge makes the read stale
                fwd_hit_reg  <= s1_valid_reg;
            end
        end
    end

    // phase update
    always_comb
    begin
        if (s1_restart_reg)
        begin
            base_pair = '0;
        end
        else if (fwd_hit_reg)
        begin
            base_pair = fwd_val_reg;
        end
        else if (rd_valid_reg)
        begin
            base_pair = rd_data_reg;
        end
        else
        begin
            base_pair = '0;
        end
        outer_next = base_pair[PAIR_W-1:PHASE_BITS] + PHASE_BITS'(outer_step_reg);
        inner_next = base_pair[PHASE_BITS-1:0] + PHASE_BITS'(inner_step_reg);
    end

    logic [PHASE_BITS-1:0] outer_phase_reg;
    logic [PHASE_BITS-1:0] inner_phase_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            outer_phase_reg <= outer_next;
            inner_phase_reg <= inner_next;
        end
    end

    // sine and cosine of both phases, registered through address and table stages
    sine_t sin_o;
    sine_t cos_o;
    sine_t sin_i;
    sine_t cos_i;

    hpg_sine_lookup #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_outer_lookup (
        .clk     (clk),
        .en      (adv),
        .phase   (outer_phase_reg),
        .sin_val (sin_o),
        .cos_val (cos_o)
    );

    hpg_sine_lookup #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_inner_lookup (
        .clk     (clk),
        .en      (adv),
        .phase   (inner_phase_reg),
        .sin_val (sin_i),
        .cos_val (cos_i)
    );

    // radius products, Q.19
    logic signed [PROD_W-1:0] x_ring_reg;
    logic signed [PROD_W-1:0] x_pen_reg;
    logic signed [PROD_W-1:0] y_ring_reg;
    logic signed [PROD_W-1:0] y_pen_reg;
    sine_t                    ring_s;
    sine_t                    pen_s;

    assign ring_s = sine_t'({1'b0, ring_radius_reg});
    assign pen_s  = sine_t'({1'b0, pen_radius_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_ring_reg <= ring_s * cos_o;
            x_pen_reg  <= pen_s * cos_i;
            y_ring_reg <= ring_s * sin_o;
            y_pen_reg  <= pen_s * sin_i;
        end
    end

    // sums with the centre
    logic signed [SUM_W-1:0] x_sum_reg;
    logic signed [SUM_W-1:0] y_sum_reg;
    logic signed [SUM_W-1:0] cx_q;
    logic signed [SUM_W-1:0] cy_q;

    assign cx_q = SUM_W'($signed({1'b0, center_x_reg, {FRAC_BITS{1'b0}}}));
    assign cy_q = SUM_W'($signed({1'b0, center_y_reg, {FRAC_BITS{1'b0}}}));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_sum_reg <= cx_q + SUM_W'(x_ring_reg) + SUM_W'(x_pen_reg);
            y_sum_reg <= cy_q - SUM_W'(y_ring_reg) + SUM_W'(y_pen_reg);
        end
    end

    // truncate toward zero to whole pixels, then saturate
    function automatic coord_t to_pixel(input logic signed [SUM_W-1:0] s);
        logic signed [Q_W-1:0] q;
        coord_t                c;
        q = s[SUM_W-1:FRAC_BITS];
        if (s[SUM_W-1] && (s[FRAC_BITS-1:0] != '0))
        begin
            q = q + Q_W'(1);
        end
        if (q > Q_MAX)
        begin
            c = COORD_W'(Q_MAX);
        end
        else if (q < Q_MIN)
        begin
            c = COORD_W'(Q_MIN);
        end
        else
        begin
            c = COORD_W'(q);
        end
        return c;
    endfunction

    coord_t point_x_reg;
    coord_t point_y_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            point_x_reg <= to_pixel(x_sum_reg);
            point_y_reg <= to_pixel(y_sum_reg);
        end
    end

    assign point.valid   = out_valid_reg;
    assign point.point_x = point_x_reg;
    assign point.point_y = point_y_reg;

    // checks
    `HPG_ASSERT_NXT(a_accept_enters_s1, clk, rst_n, step_acc, s1_valid_reg)
    `HPG_ASSERT_IMP(a_fwd_after_write, clk, rst_n, s1_valid_reg && fwd_hit_reg, mem_valid_reg)
    `HPG_ASSERT_NXT(a_restart_outer, clk, rst_n, mem_we && s1_restart_reg, outer_phase_reg == PHASE_BITS'(outer_step_reg))
    `HPG_ASSERT_NXT(a_restart_inner, clk, rst_n, mem_we && s1_restart_reg, inner_phase_reg == PHASE_BITS'(inner_step_reg))

endmodule

`default_nettype wire

// File: rtl/hpg_sine_lookup.sv
// Quarter-wave sine/cosine lookup: address stage, dual-read table, sign fold.
`timescale 1ns / 1ps
`default_nettype none

module hpg_sine_lookup
    import hpg_pkg::*;
#(
    parameter int PHASE_BITS       = PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [PHASE_BITS-1:0] phase,
    output sine_t                      sin_val,
    output sine_t                      cos_val
);

    localparam int IW    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int REM_W = PHASE_BITS - 2;
    localparam int MUL_W = REM_W + IW;
    localparam logic [PHASE_BITS-1:0] QUARTER = {2'b01, {REM_W{1'b0}}};

    typedef logic [SINE_MAG_W-1:0] rom_t [0:SINE_TABLE_DEPTH];

    // Table of sin(k/depth * pi/2) in Q15, Taylor series in Q30
    function automatic rom_t build_rom();
        rom_t        r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x  = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
            x2 = (x * x) >> 30;
            t  = (64'd1 << 30) - x2 / 64'd110;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            s  = (s + (64'd1 << 14)) >> 15;
            if (s > 64'd32768)
            begin
                s = 64'd32768;
            end
            r[k] = s[SINE_MAG_W-1:0];
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // {negate, table index} for one phase
    function automatic logic [IW:0] addr_of(input logic [PHASE_BITS-1:0] p);
        logic [MUL_W-1:0] prod;
        logic [IW-1:0]    idx;
        prod = MUL_W'(p[REM_W-1:0]) * MUL_W'(SINE_TABLE_DEPTH);
        idx  = prod[REM_W +: IW];
        // odd quadrants run the table backwards
        if (p[PHASE_BITS-2])
        begin
            idx = IW'(SINE_TABLE_DEPTH) - idx;
        end
        return {p[PHASE_BITS-1], idx};
    endfunction

    logic [IW-1:0]         sin_addr_reg;
    logic [IW-1:0]         cos_addr_reg;
    logic                  sin_neg_reg;
    logic                  cos_neg_reg;
    logic [SINE_MAG_W-1:0] sin_data_reg;
    logic [SINE_MAG_W-1:0] cos_data_reg;
    logic                  sin_neg_d_reg;
    logic                  cos_neg_d_reg;
    logic [PHASE_BITS-1:0] cos_phase;
    sine_t                 sin_mag;
    sine_t                 cos_mag;

    assign cos_phase = phase + QUARTER;

    // address stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            {sin_neg_reg, sin_addr_reg} <= addr_of(phase);
            {cos_neg_reg, cos_addr_reg} <= addr_of(cos_phase);
        end
    end

    // table read, two ports
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_data_reg  <= SINE_ROM[sin_addr_reg];
            cos_data_reg  <= SINE_ROM[cos_addr_reg];
            sin_neg_d_reg <= sin_neg_reg;
            cos_neg_d_reg <= cos_neg_reg;
        end
    end

    // sign fold for the lower half turn
    assign sin_mag = sine_t'({1'b0, sin_data_reg});
    assign cos_mag = sine_t'({1'b0, cos_data_reg});
    assign sin_val = sin_neg_d_reg ? -sin_mag : sin_mag;
    assign cos_val = cos_neg_d_reg ? -cos_mag : cos_mag;

endmodule

`default_nettype wire
